[rtl/module_atom_tokenizer_top_defines.svh]
// assertion macros for the atom tokenizer
`ifndef MODULE_ATOM_TOKENIZER_TOP_DEFINES_SVH
`define MODULE_ATOM_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication
`define MAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mat_pkg.sv]
package mat_pkg;

    localparam int MAX_NAME_LEN = 31;
    localparam int NAME_LEN_W   = 6;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = 2;

    localparam logic [26:0] INT_LIMIT = 27'd99999999;
    localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
    localparam logic [15:0] COL_MAX   = 16'hFFFF;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_NAME,
        MODE_STR,
        MODE_STRQ,
        MODE_HALT
    } mode_t;

    typedef enum logic [2:0] {
        KIND_NAME,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_INT,
        KIND_STR,
        KIND_EOF
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_EOF_IN_STR,
        ERR_INT_OVERFLOW,
        ERR_BAD_NAME_START,
        ERR_NAME_TOO_LONG
    } err_t;

    typedef struct packed {
        kind_t        token_kind;
        logic         text_valid;
        logic [7:0]   text_char;
        logic         token_end;
        logic [26:0]  int_value;
        err_t         error_code;
        logic [19:0]  line_number;
        logic [15:0]  column_number;
    } res_t;

    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= 8'h39;
    endfunction

    function automatic res_t mk_res(kind_t k, logic tv, logic [7:0] ch, logic e,
                                    logic [26:0] iv, err_t er,
                                    logic [19:0] ln, logic [15:0] cl);
        res_t r;
        r.token_kind    = k;
        r.text_valid    = tv;
        r.text_char     = ch;
        r.token_end     = e;
        r.int_value     = iv;
        r.error_code    = er;
        r.line_number   = ln;
        r.column_number = cl;
        return r;
    endfunction

endpackage

[rtl/mat_if.sv]
interface mat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface mat_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic        text_valid;
    logic [7:0]  text_char;
    logic        token_end;
    logic [26:0] int_value;
    logic [2:0]  error_code;
    logic [19:0] line_number;
    logic [15:0] column_number;

    modport source (output valid, output token_kind, output text_valid, output text_char,
                    output token_end, output int_value, output error_code,
                    output line_number, output column_number, input ready);
    modport sink   (input valid, input token_kind, input text_valid, input text_char,
                    input token_end, input int_value, input error_code,
                    input line_number, input column_number, output ready);
endinterface

[rtl/module_atom_tokenizer_top.sv]
// results of a byte pass through the queue and then the output register; a second result waits in a pending register
// one byte per cycle while the queue is not full; a byte that yields two results presents them in turn
// the output side is an output register plus a pending register, fed from a four-entry queue
// reset: asynchronous, active low; lexer idle between atoms, line and column counts zero
`include "module_atom_tokenizer_top_defines.svh"

module module_atom_tokenizer_top (
    input  logic      clk,
    input  logic      rst_n,
    mat_in_if.sink    char_ch,
    mat_out_if.source tok_ch
);
    import mat_pkg::*;

    q_push_t push;
    q_stat_t stat;
    entry_t  head;
    logic    pop;

    mat_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch),
        .push    (push),
        .stat    (stat)
    );

    mat_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    mat_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (stat),
        .pop    (pop),
        .tok_ch (tok_ch)
    );

    `MAT_ASSERT_NOW(a_queue_state, stat.full, !stat.empty, "queue full and empty at once")
    `MAT_ASSERT_NOW(a_text_not_end, tok_ch.valid && tok_ch.text_valid, !tok_ch.token_end, "text result marked as token end")
    `MAT_ASSERT_NOW(a_error_clean, tok_ch.valid && tok_ch.error_code != ERR_NONE, !tok_ch.token_end && !tok_ch.text_valid, "error result carries token data")
    `MAT_ASSERT_NOW(a_full_stalls, stat.full, !char_ch.ready, "transfer offered to a full queue")

endmodule

[rtl/mat_front.sv]
module mat_front (
    input  logic             clk,
    input  logic             rst_n,
    mat_in_if.sink           char_ch,
    output mat_pkg::q_push_t push,
    input  mat_pkg::q_stat_t stat
);
    import mat_pkg::*;

    mode_t                 mode_reg, mode_next;
    logic [26:0]           acc_reg, acc_next;
    logic [NAME_LEN_W-1:0] len_reg, len_next;
    logic [19:0]           line_reg, line_next;
    logic [15:0]           col_reg, col_next;

    logic        fire;
    logic [7:0]  c;
    logic        eof;
    logic [29:0] mac;
    logic [1:0]  n_res;
    res_t        res0, res1, close_res, start_res;
    logic        has_close, has_start, do_start;
    mode_t       start_mode;
    logic        start_acc, start_len;

    assign c             = char_ch.char_in;
    assign eof           = char_ch.end_of_input;
    assign char_ch.ready = !stat.full;
    assign fire          = char_ch.valid && char_ch.ready;

    // acc * 10 + digit as shift-add
    assign mac = ({3'b000, acc_reg} << 3) + ({3'b000, acc_reg} << 1) + {26'd0, c[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        n_res      = 2'd0;
        res0       = '0;
        res1       = '0;
        close_res  = '0;
        start_res  = '0;
        has_close  = 1'b0;
        has_start  = 1'b0;
        do_start   = 1'b0;
        start_mode = MODE_IDLE;
        start_acc  = 1'b0;
        start_len  = 1'b0;

        if (mode_reg != MODE_HALT)
        begin
            // line and column counts
            if (!eof && c == CH_NEWLINE)
            begin
                if (line_reg < LINE_MAX)
                    line_next = line_reg + 20'd1;
                col_next = 16'd1;
            end
            else if (col_reg < COL_MAX)
            begin
                col_next = col_reg + 16'd1;
            end

            // this byte as the start of a new atom
            if (eof)
            begin
                has_start = 1'b1;
                start_res = mk_res(KIND_EOF, 1'b0, 8'd0, 1'b1, 27'd0, ERR_NONE,
                                   line_next, col_next);
            end
            else if (c == CH_SPACE || c == CH_NEWLINE)
            begin
                has_start = 1'b0;
            end
            else if (c == CH_LPAREN)
            begin
                has_start = 1'b1;
                start_res = mk_res(KIND_LPAREN, 1'b0, 8'd0, 1'b1, 27'd0, ERR_NONE,
                                   line_next, col_next);
            end
            else if (c == CH_RPAREN)
            begin
                has_start = 1'b1;
                start_res = mk_res(KIND_RPAREN, 1'b0, 8'd0, 1'b1, 27'd0, ERR_NONE,
                                   line_next, col_next);
            end
            else if (c == CH_QUOTE)
            begin
                start_mode = MODE_STR;
            end
            else if (is_digit(c))
            begin
                start_mode = MODE_INT;
                start_acc  = 1'b1;
            end
            else if (is_letter(c))
            begin
                start_mode = MODE_NAME;
                start_len  = 1'b1;
                has_start  = 1'b1;
                start_res  = mk_res(KIND_NAME, 1'b1, c, 1'b0, 27'd0, ERR_NONE,
                                    line_next, col_next);
            end
            else
            begin
                start_mode = MODE_HALT;
                has_start  = 1'b1;
                start_res  = mk_res(KIND_NAME, 1'b0, 8'd0, 1'b0, 27'd0,
                                    ERR_BAD_NAME_START, line_next, col_next);
            end

            unique case (mode_reg)
                MODE_INT:
                begin
                    if (!eof && is_digit(c))
                    begin
                        if (mac > {3'b000, INT_LIMIT})
                        begin
                            mode_next = MODE_HALT;
                            n_res     = 2'd1;
                            res0      = mk_res(KIND_NAME, 1'b0, 8'd0, 1'b0, 27'd0,
                                               ERR_INT_OVERFLOW, line_next, col_next);
                        end
                        else
                        begin
                            acc_next = mac[26:0];
                        end
                    end
                    else
                    begin
                        has_close = 1'b1;
                        close_res = mk_res(KIND_INT, 1'b0, 8'd0, 1'b1, acc_reg, ERR_NONE,
                                           line_next, col_next);
                        do_start  = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    if (!eof && (is_letter(c) || is_digit(c) || c == CH_UNDERSCORE))
                    begin
                        n_res = 2'd1;
                        if (len_reg >= NAME_LEN_W'(MAX_NAME_LEN))
                        begin
                            mode_next = MODE_HALT;
                            res0      = mk_res(KIND_NAME, 1'b0, 8'd0, 1'b0, 27'd0,
                                               ERR_NAME_TOO_LONG, line_next, col_next);
                        end
                        else
                        begin
                            len_next = len_reg + NAME_LEN_W'(1);
                            res0     = mk_res(KIND_NAME, 1'b1, c, 1'b0, 27'd0, ERR_NONE,
                                              line_next, col_next);
                        end
                    end
                    else
                    begin
                        has_close = 1'b1;
                        close_res = mk_res(KIND_NAME, 1'b0, 8'd0, 1'b1, 27'd0, ERR_NONE,
                                           line_next, col_next);
                        do_start  = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    n_res = 2'd1;
                    if (eof)
                    begin
                        mode_next = MODE_HALT;
                        res0      = mk_res(KIND_NAME, 1'b0, 8'd0, 1'b0, 27'd0,
                                           ERR_EOF_IN_STR, line_next, col_next);
                    end
                    else if (c == CH_QUOTE)
                    begin
                        mode_next = MODE_STRQ;
                        n_res     = 2'd0;
                    end
                    else
                    begin
                        res0 = mk_res(KIND_STR, 1'b1, c, 1'b0, 27'd0, ERR_NONE,
                                      line_next, col_next);
                    end
                end
                MODE_STRQ:
                begin
                    if (!eof && c == CH_QUOTE)
                    begin
                        mode_next = MODE_STR;
                        n_res     = 2'd1;
                        res0      = mk_res(KIND_STR, 1'b1, c, 1'b0, 27'd0, ERR_NONE,
                                           line_next, col_next);
                    end
                    else
                    begin
                        has_close = 1'b1;
                        close_res = mk_res(KIND_STR, 1'b0, 8'd0, 1'b1, 27'd0, ERR_NONE,
                                           line_next, col_next);
                        do_start  = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start)
            begin
                mode_next = start_mode;
                if (start_acc)
                    acc_next = {23'd0, c[3:0]};
                if (start_len)
                    len_next = NAME_LEN_W'(1);
                if (has_close)
                begin
                    res0  = close_res;
                    res1  = start_res;
                    n_res = has_start ? 2'd2 : 2'd1;
                end
                else
                begin
                    res0  = start_res;
                    n_res = has_start ? 2'd1 : 2'd0;
                end
            end
        end
    end

    assign push.valid        = fire && (n_res != 2'd0);
    assign push.entry.two    = (n_res == 2'd2);
    assign push.entry.first  = res0;
    assign push.entry.second = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            len_reg  <= '0;
            line_reg <= '0;
            col_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            len_reg  <= len_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

[rtl/mat_queue.sv]
module mat_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  mat_pkg::q_push_t push,
    input  logic             pop,
    output mat_pkg::entry_t  head,
    output mat_pkg::q_stat_t stat
);
    import mat_pkg::*;

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign stat.full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QUEUE_AW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QUEUE_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.entry;
    end

endmodule

[rtl/mat_back.sv]
module mat_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mat_pkg::entry_t  head,
    input  mat_pkg::q_stat_t stat,
    output logic             pop,
    mat_out_if.source        tok_ch
);
    import mat_pkg::*;

    res_t out_reg, pend_reg;
    logic out_valid_reg, pend_valid_reg;
    logic load;

    // output register free or being drained this cycle
    assign load = !out_valid_reg || tok_ch.ready;
    assign pop  = load && !pend_valid_reg && !stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= pend_valid_reg || !stat.empty;
            if (pend_valid_reg)
                pend_valid_reg <= 1'b0;
            else if (!stat.empty)
                pend_valid_reg <= head.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
            end
            else if (!stat.empty)
            begin
                out_reg  <= head.first;
                pend_reg <= head.second;
            end
        end
    end

    assign tok_ch.valid         = out_valid_reg;
    assign tok_ch.token_kind    = out_reg.token_kind;
    assign tok_ch.text_valid    = out_reg.text_valid;
    assign tok_ch.text_char     = out_reg.text_char;
    assign tok_ch.token_end     = out_reg.token_end;
    assign tok_ch.int_value     = out_reg.int_value;
    assign tok_ch.error_code    = out_reg.error_code;
    assign tok_ch.line_number   = out_reg.line_number;
    assign tok_ch.column_number = out_reg.column_number;

endmodule

[dv/module_atom_tokenizer_top_test.sv]
module module_atom_tokenizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mat_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [7:0]  UPPER_A     = 8'h41;
    localparam logic [7:0]  UPPER_Z     = 8'h5A;
    localparam logic [7:0]  LOWER_A     = 8'h61;
    localparam logic [7:0]  LOWER_Z     = 8'h7A;
    localparam logic [7:0]  DIGIT_NINE  = 8'h39;

    typedef enum int {
        PIECE_NONE,
        PIECE_NAME,
        PIECE_INT,
        PIECE_OTHER
    } piece_e;

    class token_scoreboard;
        mode_t       mode;
        logic [26:0] acc;
        logic [5:0]  name_len;
        logic [19:0] line;
        logic [15:0] col;
        res_t        tokens_due[$];
        int          mismatches;
        int          bytes_seen;
        int          tokens_seen;
        err_t        stop_code;

        function new();
            mode        = MODE_IDLE;
            acc         = '0;
            name_len    = '0;
            line        = '0;
            col         = '0;
            mismatches  = 0;
            bytes_seen  = 0;
            tokens_seen = 0;
            stop_code   = ERR_NONE;
        endfunction

        static function bit alpha(logic [7:0] c);
            return (c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z);
        endfunction

        static function bit numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= DIGIT_NINE;
        endfunction

        static function bit starter(logic [7:0] c);
            return c == CH_SPACE || c == CH_NEWLINE || c == CH_LPAREN || c == CH_RPAREN
                || c == CH_QUOTE || numeral(c) || alpha(c);
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function void stamp(kind_t k, logic tv, logic [7:0] ch, logic fin,
                            logic [26:0] v, err_t er);
            res_t r;
            r.token_kind    = k;
            r.text_valid    = tv;
            r.text_char     = ch;
            r.token_end     = fin;
            r.int_value     = v;
            r.error_code    = er;
            r.line_number   = line;
            r.column_number = col;
            tokens_due.push_back(r);
        endfunction

        function void stop(err_t er);
            mode      = MODE_HALT;
            stop_code = er;
            stamp(KIND_NAME, 1'b0, 8'h00, 1'b0, 27'd0, er);
        endfunction

        function void open_atom(logic [7:0] c, logic e);
            mode = MODE_IDLE;
            if (e)
                stamp(KIND_EOF, 1'b0, 8'h00, 1'b1, 27'd0, ERR_NONE);
            else if (c == CH_LPAREN)
                stamp(KIND_LPAREN, 1'b0, 8'h00, 1'b1, 27'd0, ERR_NONE);
            else if (c == CH_RPAREN)
                stamp(KIND_RPAREN, 1'b0, 8'h00, 1'b1, 27'd0, ERR_NONE);
            else if (c == CH_QUOTE)
                mode = MODE_STR;
            else if (numeral(c))
            begin
                acc  = 27'(c - CH_ZERO);
                mode = MODE_INT;
            end
            else if (alpha(c))
            begin
                name_len = 6'd1;
                mode     = MODE_NAME;
                stamp(KIND_NAME, 1'b1, c, 1'b0, 27'd0, ERR_NONE);
            end
            else if (c != CH_SPACE && c != CH_NEWLINE)
                stop(ERR_BAD_NAME_START);
        endfunction

        function void note_byte(logic [7:0] c, logic e);
            logic [31:0] grown;
            bytes_seen++;
            if (mode == MODE_HALT)
                return;
            if (!e && c == CH_NEWLINE)
            begin
                if (line != LINE_MAX)
                    line++;
                col = 16'd1;
            end
            else if (col != COL_MAX)
                col++;
            case (mode)
                MODE_INT:
                begin
                    if (!e && numeral(c))
                    begin
                        grown = 32'(acc) * 32'd10 + 32'(c - CH_ZERO);
                        if (grown > 32'(INT_LIMIT))
                            stop(ERR_INT_OVERFLOW);
                        else
                            acc = grown[26:0];
                    end
                    else
                    begin
                        stamp(KIND_INT, 1'b0, 8'h00, 1'b1, acc, ERR_NONE);
                        open_atom(c, e);
                    end
                end
                MODE_NAME:
                begin
                    if (!e && (alpha(c) || numeral(c) || c == CH_UNDERSCORE))
                    begin
                        if (name_len >= MAX_NAME_LEN)
                            stop(ERR_NAME_TOO_LONG);
                        else
                        begin
                            name_len++;
                            stamp(KIND_NAME, 1'b1, c, 1'b0, 27'd0, ERR_NONE);
                        end
                    end
                    else
                    begin
                        stamp(KIND_NAME, 1'b0, 8'h00, 1'b1, 27'd0, ERR_NONE);
                        open_atom(c, e);
                    end
                end
                MODE_STR:
                begin
                    if (e)
                        stop(ERR_EOF_IN_STR);
                    else if (c == CH_QUOTE)
                        mode = MODE_STRQ;
                    else
                        stamp(KIND_STR, 1'b1, c, 1'b0, 27'd0, ERR_NONE);
                end
                MODE_STRQ:
                begin
                    if (!e && c == CH_QUOTE)
                    begin
                        mode = MODE_STR;
                        stamp(KIND_STR, 1'b1, c, 1'b0, 27'd0, ERR_NONE);
                    end
                    else
                    begin
                        stamp(KIND_STR, 1'b0, 8'h00, 1'b1, 27'd0, ERR_NONE);
                        open_atom(c, e);
                    end
                end
                default:
                    open_atom(c, e);
            endcase
        endfunction

        function void field_check(string f, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, f, want, got);
                mismatches++;
            end
        endfunction

        function void check_token(res_t got);
            res_t want;
            tokens_seen++;
            if (tokens_due.size() == 0)
            begin
                $display("%0t: result with nothing due, expected none actual kind %0d err %0d",
                         $time, got.token_kind, got.error_code);
                mismatches++;
                return;
            end
            want = tokens_due.pop_front();
            field_check("token_kind", want.token_kind, got.token_kind);
            field_check("text_valid", want.text_valid, got.text_valid);
            field_check("text_char", want.text_char, got.text_char);
            field_check("token_end", want.token_end, got.token_end);
            field_check("int_value", want.int_value, got.int_value);
            field_check("error_code", want.error_code, got.error_code);
            field_check("line_number", want.line_number, got.line_number);
            field_check("column_number", want.column_number, got.column_number);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   in_idle = 19;
    int   out_idle = 19;
    int   busy_items = 0;

    token_scoreboard sb = new();

    mat_in_if  char_ch();
    mat_out_if tok_ch();

    module_atom_tokenizer_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .char_ch(char_ch),
        .tok_ch (tok_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[module_atom_tokenizer_top] ERROR");
            $finish;
        end
    end

    initial
    begin : result_side
        res_t got;
        tok_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1)
            begin
                got.token_kind    = kind_t'(tok_ch.token_kind);
                got.text_valid    = tok_ch.text_valid;
                got.text_char     = tok_ch.text_char;
                got.token_end     = tok_ch.token_end;
                got.int_value     = tok_ch.int_value;
                got.error_code    = err_t'(tok_ch.error_code);
                got.line_number   = tok_ch.line_number;
                got.column_number = tok_ch.column_number;
                sb.check_token(got);
            end
            tok_ch.ready <= ($urandom_range(99, 0) >= out_idle);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic e);
        while ($urandom_range(99, 0) < in_idle)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid        <= 1'b1;
        char_ch.char_in      <= c;
        char_ch.end_of_input <= e;
        @(posedge clk);
        while (char_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_byte(c, e);
        busy_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // hold the sender until every pending result has been taken
    task automatic drain();
        char_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(51, 0);
        return (r < 26) ? UPPER_A + 8'(r) : LOWER_A + 8'(r - 26);
    endfunction

    function automatic logic [7:0] pick_tail();
        int r;
        r = $urandom_range(62, 0);
        if (r < 52)
            return pick_letter();
        if (r < 62)
            return CH_ZERO + 8'(r - 52);
        return CH_UNDERSCORE;
    endfunction

    task automatic send_name(input int len);
        send_byte(pick_letter(), 1'b0);
        repeat (len - 1)
            send_byte(pick_tail(), 1'b0);
    endtask

    task automatic send_int();
        int zeros;
        zeros = ($urandom_range(3, 0) == 0) ? $urandom_range(12, 1) : 0;
        repeat (zeros)
            send_byte(CH_ZERO, 1'b0);
        if ($urandom_range(7, 0) == 0)
            repeat (8) send_byte(DIGIT_NINE, 1'b0);
        else
            repeat ($urandom_range(8, 1)) send_byte(CH_ZERO + 8'($urandom_range(9, 0)), 1'b0);
    endtask

    task automatic send_string();
        logic [7:0] c;
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(10, 0))
        begin
            c = ($urandom_range(7, 0) == 0) ? CH_QUOTE : 8'($urandom_range(255, 0));
            send_byte(c, 1'b0);
            if (c == CH_QUOTE)
                send_byte(c, 1'b0);
        end
        send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic send_gap(input bit needed);
        int sel;
        sel = $urandom_range(3, 0);
        if (sel == 0 && needed)
            sel = 1;
        case (sel)
            1: send_byte(CH_SPACE, 1'b0);
            2: send_byte(CH_NEWLINE, 1'b0);
            3: repeat ($urandom_range(4, 2))
                   send_byte($urandom_range(1, 0) ? CH_SPACE : CH_NEWLINE, 1'b0);
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        int         start_count;
        int         pick;
        bit         paused;
        piece_e     prev;
        piece_e     next;
        logic [7:0] c;
        rst_n                <= 1'b0;
        char_ch.valid        <= 1'b0;
        char_ch.char_in      <= 8'h00;
        char_ch.end_of_input <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("(Az_9 99999999)'a''b'");
        send_byte(8'h00, 1'b1);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        start_count = busy_items;
        prev        = PIECE_NONE;
        paused      = 1'b0;
        while (busy_items - start_count < 450)
        begin
            in_idle  = (busy_items - start_count < 120) ? 0 : 19;
            out_idle = in_idle;
            if (!paused && busy_items - start_count >= 240)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(99, 0);
            if (pick >= 28 && pick < 48)
                next = PIECE_INT;
            else if (pick >= 48 && pick < 68)
                next = PIECE_NAME;
            else
                next = PIECE_OTHER;
            send_gap((prev == PIECE_NAME || prev == PIECE_INT)
                     && (next == PIECE_NAME || next == PIECE_INT));
            if (pick < 14)
                send_byte(CH_LPAREN, 1'b0);
            else if (pick < 28)
                send_byte(CH_RPAREN, 1'b0);
            else if (pick < 48)
                send_int();
            else if (pick < 68)
                send_name(($urandom_range(5, 0) == 0) ? MAX_NAME_LEN : $urandom_range(10, 1));
            else if (pick < 88)
                send_string();
            else
                send_byte(8'($urandom_range(255, 0)), 1'b1);
            prev = next;
        end

        // the run ends on one error, after which the lexer stays halted
        send_byte(CH_SPACE, 1'b0);
        case ($urandom_range(3, 0))
            0:
            begin
                send_text("'ab");
                send_byte(8'($urandom_range(255, 0)), 1'b1);
            end
            1:
            begin
                send_byte(CH_ZERO + 8'd1, 1'b0);
                repeat (8) send_byte(CH_ZERO + 8'($urandom_range(9, 0)), 1'b0);
            end
            2:
            begin
                do
                    c = 8'($urandom_range(255, 0));
                while (token_scoreboard::starter(c));
                if ($urandom_range(3, 0) == 0)
                    c = CH_UNDERSCORE;
                send_byte(c, 1'b0);
            end
            default:
                send_name(MAX_NAME_LEN + 1);
        endcase
        repeat (16)
            send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
        drain();
        repeat (8) @(posedge clk);

        $display("sent %0d bytes: parens, integers, names, strings, end marks, stalled and not",
                 sb.bytes_seen);
        $display("checked %0d results, run closed by error code %0d", sb.tokens_seen,
                 sb.stop_code);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[module_atom_tokenizer_top] OK");
        else
            $display("[module_atom_tokenizer_top] ERROR");
        $finish;
    end

endmodule
